@@ sv/b64d_pkg.sv @@
// Shared types, constants and the character classifier for the base64 stream decoder.
`timescale 1ns / 1ps
`default_nettype none

package b64d_pkg;

    // Width of the expected size register
    localparam int unsigned SIZE_W = 24;

    // Depth of the queue between front and back; a power of two
    localparam int unsigned QDEPTH = 2;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    // ASCII codes used by the classifier
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_EQUALS  = 8'h3D;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;

    // Symbol value offsets
    localparam logic [7:0] VAL_LOWER_BASE = 8'd26;
    localparam logic [7:0] VAL_DIGIT_BASE = 8'd52;
    localparam logic [5:0] VAL_PLUS       = 6'd62;
    localparam logic [5:0] VAL_SLASH      = 6'd63;

    // Character class decided by the front
    typedef enum logic [1:0] {
        CLS_SYM  = 2'd0,
        CLS_PAD  = 2'd1,
        CLS_SKIP = 2'd2,
        CLS_BAD  = 2'd3
    } t_cls;

    // Result kind
    typedef enum logic [1:0] {
        KIND_DATA     = 2'd0,
        KIND_DONE     = 2'd1,
        KIND_INVALID  = 2'd2,
        KIND_MISMATCH = 2'd3
    } t_kind;

    // One classified item in the queue
    typedef struct packed {
        t_cls       cls;
        logic [5:0] value;
        logic       last;
    } t_entry;

    // One result item
    typedef struct packed {
        logic [7:0] data_byte;
        t_kind      kind;
        logic       final_res;
    } t_result;

    // Map one character to its class and 6-bit symbol value
    function automatic t_entry classify(input logic [7:0] c, input logic last);
        t_entry e;
        e.cls   = CLS_BAD;
        e.value = 6'd0;
        e.last  = last;
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            e.cls   = CLS_SYM;
            e.value = 6'(c - CH_UPPER_A);
        end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
            e.cls   = CLS_SYM;
            e.value = 6'(c - CH_LOWER_A + VAL_LOWER_BASE);
        end else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
            e.cls   = CLS_SYM;
            e.value = 6'(c - CH_DIGIT_0 + VAL_DIGIT_BASE);
        end else if (c == CH_PLUS) begin
            e.cls   = CLS_SYM;
            e.value = VAL_PLUS;
        end else if (c == CH_SLASH) begin
            e.cls   = CLS_SYM;
            e.value = VAL_SLASH;
        end else if (c == CH_EQUALS) begin
            e.cls   = CLS_PAD;
        end else if (c == CH_CR || c == CH_LF || c == CH_SPACE || c == CH_TAB) begin
            e.cls   = CLS_SKIP;
        end
        return e;
    endfunction

endpackage

`default_nettype wire

@@ sv/b64d_front.sv @@
// Front end: accepts characters and classifies them into queue entries.
`timescale 1ns / 1ps
`default_nettype none

module b64d_front
    import b64d_pkg::*;
(
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_char,
    input  wire logic       i_last,
    input  wire logic       i_q_full,
    output logic            o_push,
    output t_entry          o_entry
);

    // Accept whenever the queue has room
    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    // Classify the character
    always_comb begin
        o_entry = classify(i_char, i_last);
    end

endmodule

`default_nettype wire

@@ sv/b64d_queue.sv @@
// Short queue of classified items between front and back.
`timescale 1ns / 1ps
`default_nettype none

module b64d_queue
    import b64d_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_entry i_entry,
    output logic        o_full,
    input  wire logic   i_pop,
    output logic        o_valid,
    output t_entry      o_head
);

    t_entry              r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;
    logic                do_pop;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // Advance pointers and track fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/b64d_back.sv @@
// Back end: decoding state, byte assembly, final status and the output register.
`timescale 1ns / 1ps
`default_nettype none

module b64d_back
    import b64d_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = 24
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [SIZE_W-1:0] i_cfg_wdata,
    input  wire logic              i_q_valid,
    input  wire t_entry            i_q_head,
    output logic                   o_q_pop,
    output logic                   o_res_valid,
    input  wire logic              i_res_ready,
    output t_result                o_res
);

    localparam int unsigned CMP_W = (COUNT_WIDTH > SIZE_W) ? COUNT_WIDTH : SIZE_W;

    typedef enum logic [1:0] {
        MODE_ACTIVE  = 2'd0,
        MODE_STOPPED = 2'd1,
        MODE_ERROR   = 2'd2
    } t_mode;

    logic [SIZE_W-1:0]      r_expected;
    logic [11:0]            r_buf;
    logic [2:0]             r_bits;
    t_mode                  r_mode;
    logic [COUNT_WIDTH-1:0] r_count;
    logic                   r_ovalid;
    t_result                r_out;
    logic                   r_pend_valid;
    t_result                r_pend;

    logic [11:0]            n_buf;
    logic [2:0]             n_bits;
    t_mode                  n_mode;
    logic [COUNT_WIDTH-1:0] n_count;
    logic                   active;
    logic                   emit;
    logic                   bad;
    logic                   err_res;
    logic [7:0]             byte_val;
    t_kind                  fin_kind;
    logic                   any_res;
    logic                   two_res;
    t_result                first_res;
    t_result                fin_res;
    logic                   out_free;
    logic                   pop;

    // Hold the expected size
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected <= '0;
        end else if (i_cfg_we) begin
            r_expected <= i_cfg_wdata;
        end
    end

    // Work out the effect of the head item
    always_comb begin
        active   = (r_mode == MODE_ACTIVE);
        emit     = 1'b0;
        bad      = active && (i_q_head.cls == CLS_BAD);
        err_res  = bad && !i_q_head.last;
        n_buf    = r_buf;
        n_bits   = r_bits;
        n_mode   = r_mode;
        n_count  = r_count;
        byte_val = 8'd0;
        if (active) begin
            unique case (i_q_head.cls)
                CLS_SYM: begin
                    n_buf = {r_buf[5:0], i_q_head.value};
                    if (r_bits >= 3'd2) begin
                        emit     = 1'b1;
                        n_bits   = r_bits - 3'd2;
                        byte_val = n_buf[n_bits +: 8];
                        if (r_count != '1) begin
                            n_count = r_count + 1'b1;
                        end
                    end else begin
                        n_bits = r_bits + 3'd6;
                    end
                end
                CLS_PAD:  n_mode = MODE_STOPPED;
                CLS_SKIP: n_mode = r_mode;
                CLS_BAD:  n_mode = MODE_ERROR;
                default:  n_mode = r_mode;
            endcase
        end

        // Final status precedence: error, then count mismatch, then done
        if (n_mode == MODE_ERROR) begin
            fin_kind = KIND_INVALID;
        end else if (CMP_W'(n_count) != CMP_W'(r_expected)) begin
            fin_kind = KIND_MISMATCH;
        end else begin
            fin_kind = KIND_DONE;
        end
        fin_res = '{data_byte: 8'd0, kind: fin_kind, final_res: 1'b1};

        priority if (emit) begin
            first_res = '{data_byte: byte_val, kind: KIND_DATA, final_res: 1'b0};
        end else if (err_res) begin
            first_res = '{data_byte: 8'd0, kind: KIND_INVALID, final_res: 1'b0};
        end else begin
            first_res = fin_res;
        end

        any_res = emit || err_res || i_q_head.last;
        two_res = (emit || err_res) && i_q_head.last;
    end

    // Pop when nothing is pending and the result can land
    assign out_free = !r_ovalid || i_res_ready;
    assign pop      = i_q_valid && !r_pend_valid && (out_free || !any_res);
    assign o_q_pop  = pop;

    // Update decoding state; clear it after the last character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf   <= '0;
            r_bits  <= '0;
            r_mode  <= MODE_ACTIVE;
            r_count <= '0;
        end else if (pop) begin
            if (i_q_head.last) begin
                r_buf   <= '0;
                r_bits  <= '0;
                r_mode  <= MODE_ACTIVE;
                r_count <= '0;
            end else begin
                r_buf   <= n_buf;
                r_bits  <= n_bits;
                r_mode  <= n_mode;
                r_count <= n_count;
            end
        end
    end

    // Output register and the pending second result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid     <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            if (r_pend_valid && out_free) begin
                r_ovalid     <= 1'b1;
                r_pend_valid <= 1'b0;
            end else if (pop && any_res) begin
                r_ovalid     <= 1'b1;
                r_pend_valid <= two_res;
            end else if (out_free) begin
                r_ovalid     <= 1'b0;
            end
        end
    end

    // Result payloads
    always_ff @(posedge i_clk) begin
        if (r_pend_valid && out_free) begin
            r_out <= r_pend;
        end else if (pop && any_res) begin
            r_out <= first_res;
        end
        if (pop && two_res) begin
            r_pend <= fin_res;
        end
    end

    assign o_res_valid = r_ovalid;
    assign o_res       = r_out;

endmodule

`default_nettype wire

@@ sv/base64_stream_decoder.sv @@
// Top level of the base64 stream decoder.
// Usage:
//   Slave channel: one ASCII character per item in s_tdata, s_tlast on the
//   last character of an encoded string. The master channel carries decoded
//   bytes (tuser kind 0) and one final status per string (tlast high, kind
//   1 done, 2 invalid character, 3 byte count mismatch).
//   The expected byte count is written through i_cfg_we/i_cfg_wdata while idle.
// Timing:
//   A front classifier pushes each character into a two-entry queue; the back
//   end pops one entry per cycle while nothing is pending and any result can
//   land, updates the bit buffer and fills a one-item output register plus one
//   pending slot. A result is registered as its entry is popped. One character
//   is taken per cycle while the queue has room; a character yielding a byte
//   and the final status parks the status in the pending slot, blocking pops.
// Reset and stall:
//   Synchronous reset clears the queue, the decoding state, the expected size
//   and the output valid. When the receiver stalls, results hold, the queue
//   fills and o_s_tready falls once both entries are occupied.
`timescale 1ns / 1ps
`default_nettype none

module base64_stream_decoder
    import b64d_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = 24
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [SIZE_W-1:0] i_cfg_wdata,   // expected_size
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire logic [7:0]        i_s_tdata,     // [7:0] character
    input  wire logic              i_s_tlast,     // end_of_string
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output logic [7:0]             o_m_tdata,     // [7:0] data_byte
    output logic [1:0]             o_m_tuser,     // [1:0] kind
    output logic                   o_m_tlast      // final_res
);

    logic    q_full;
    logic    q_push;
    t_entry  q_in;
    logic    q_pop;
    logic    q_valid;
    t_entry  q_head;
    logic    res_valid;
    t_result res;

    b64d_front u_front (
        .i_valid  (i_s_tvalid),
        .o_ready  (o_s_tready),
        .i_char   (i_s_tdata),
        .i_last   (i_s_tlast),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_entry  (q_in)
    );

    b64d_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    b64d_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_valid   (q_valid),
        .i_q_head    (q_head),
        .o_q_pop     (q_pop),
        .o_res_valid (res_valid),
        .i_res_ready (i_m_tready),
        .o_res       (res)
    );

    // Drive the master channel from the result register
    assign o_m_tvalid = res_valid;
    assign o_m_tdata  = res.data_byte;
    assign o_m_tuser  = res.kind;
    assign o_m_tlast  = res.final_res;

endmodule

`default_nettype wire

@@ verif/tb_base64_stream_decoder.sv @@
// Self-checking testbench for base64_stream_decoder: directed and random strings vs a predictor.
`timescale 1ns / 1ps

module tb_base64_stream_decoder;
    import b64d_pkg::*;

    localparam int unsigned COUNT_W     = 24;
    localparam int          RANDOM_ITEMS = 1700;
    localparam int          NUM_PHASES  = 8;
    localparam int          SETTLE      = 8;
    localparam int          TAIL        = 10;
    localparam int          CYCLE_LIMIT = 1500000;

    // Decoding mode of the predictor
    typedef enum logic [1:0] {
        DEC_ACTIVE  = 2'd0,
        DEC_STOPPED = 2'd1,
        DEC_ERROR   = 2'd2
    } t_dec_mode;

    // One character waiting to be sent
    typedef struct {
        logic [7:0] ch;
        logic       last;
    } t_char_item;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_cfg_we    = 1'b0;
    logic [SIZE_W-1:0] i_cfg_wdata = '0;
    logic              i_s_tvalid  = 1'b0;
    logic              o_s_tready;
    logic [7:0]        i_s_tdata   = '0;   // [7:0] character
    logic              i_s_tlast   = 1'b0; // end_of_string
    logic              o_m_tvalid;
    logic              i_m_tready  = 1'b0;
    logic [7:0]        o_m_tdata;          // [7:0] data_byte
    logic [1:0]        o_m_tuser;          // [1:0] kind
    logic              o_m_tlast;          // final_res

    base64_stream_decoder #(
        .COUNT_WIDTH(COUNT_W)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    // Decoder state as predicted
    logic [SIZE_W-1:0]  size_reg;
    logic [11:0]        dec_buf;
    int                 dec_bits;
    t_dec_mode          dec_mode;
    logic [COUNT_W-1:0] dec_count;

    t_char_item chars_to_send[$];
    t_result    results_due[$];
    int         bad_results = 0;
    bit         char_taken  = 1'b0;
    bit         calm        = 1'b0;
    int         send_wait   = 0;
    int         recv_wait   = 0;
    int         cycles      = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // 6-bit value of a base64 symbol, -1 for anything else
    function automatic int sym_value(input logic [7:0] c);
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z) return int'(c - CH_UPPER_A);
        if (c >= CH_LOWER_A && c <= CH_LOWER_Z) return int'(c - CH_LOWER_A) + VAL_LOWER_BASE;
        if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) return int'(c - CH_DIGIT_0) + VAL_DIGIT_BASE;
        if (c == CH_PLUS) return VAL_PLUS;
        if (c == CH_SLASH) return VAL_SLASH;
        return -1;
    endfunction

    // Character that encodes a 6-bit value
    function automatic logic [7:0] sym_char(input int v);
        if (v < VAL_LOWER_BASE) return CH_UPPER_A + 8'(v);
        if (v < VAL_DIGIT_BASE) return CH_LOWER_A + 8'(v - VAL_LOWER_BASE);
        if (v < VAL_PLUS) return CH_DIGIT_0 + 8'(v - VAL_DIGIT_BASE);
        if (v == VAL_PLUS) return CH_PLUS;
        return CH_SLASH;
    endfunction

    function automatic logic [7:0] blank_char();
        case ($urandom_range(0, 3))
            0: return CH_CR;
            1: return CH_LF;
            2: return CH_SPACE;
            default: return CH_TAB;
        endcase
    endfunction

    // Idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_result make_result(input logic [7:0] b, input t_kind k,
                                            input logic fin);
        t_result r;
        r.data_byte = b;
        r.kind      = k;
        r.final_res = fin;
        return r;
    endfunction

    // Append one expected result
    task automatic add_result(input t_result r);
        results_due = {results_due, r};
    endtask

    task automatic clear_string();
        dec_buf   = '0;
        dec_bits  = 0;
        dec_mode  = DEC_ACTIVE;
        dec_count = '0;
    endtask

    // Advance the predicted decoder by one character and queue its results
    task automatic decode_char(input logic [7:0] ch, input logic last);
        int    v;
        t_kind fin_kind;
        v = sym_value(ch);
        if (dec_mode == DEC_ACTIVE) begin
            if (ch == CH_EQUALS) begin
                dec_mode = DEC_STOPPED;
            end else if (v >= 0) begin
                dec_buf  = {dec_buf[5:0], 6'(v)};
                dec_bits = dec_bits + 6;
                if (dec_bits >= 8) begin
                    dec_bits = dec_bits - 8;
                    add_result(make_result(8'(dec_buf >> dec_bits), KIND_DATA, 1'b0));
                    if (dec_count != '1) dec_count = dec_count + 1'b1;
                end
            end else if (ch == CH_CR || ch == CH_LF || ch == CH_SPACE || ch == CH_TAB) begin
                // skip white space
            end else begin
                dec_mode = DEC_ERROR;
                if (!last) add_result(make_result(8'h00, KIND_INVALID, 1'b0));
            end
        end
        if (last) begin
            if (dec_mode == DEC_ERROR) fin_kind = KIND_INVALID;
            else if (32'(dec_count) != 32'(size_reg)) fin_kind = KIND_MISMATCH;
            else fin_kind = KIND_DONE;
            add_result(make_result(8'h00, fin_kind, 1'b1));
            clear_string();
        end
    endtask

    task automatic push_char(input logic [7:0] ch, input logic last);
        t_char_item it;
        it.ch   = ch;
        it.last = last;
        chars_to_send = {chars_to_send, it};
    endtask

    // Queue one string that decodes to nbytes bytes, optionally broken
    task automatic add_string(input int nbytes, input bit mangle, output int counted);
        logic [7:0] body[$];
        int         nsym;
        int         m;
        int         junk;
        nsym = (4 * nbytes + 2) / 3;
        for (int i = 0; i < nsym; i++) begin
            if ($urandom_range(0, 7) == 0) body = {body, blank_char()};
            body = {body, sym_char($urandom_range(0, 63))};
        end
        if (nbytes > 0 && $urandom_range(0, 1) == 1) begin
            while (nsym % 4 != 0) begin
                body = {body, CH_EQUALS};
                nsym++;
            end
        end
        if (body.size() == 0) begin
            if ($urandom_range(0, 1) == 1) body = {body, CH_EQUALS};
            else body = {body, blank_char()};
        end
        if ($urandom_range(0, 5) == 0) body = {body, blank_char()};
        counted = body.size();
        if (mangle) begin
            m = $urandom_range(0, 2);
            if (m == 0) begin
                // drop a random byte somewhere into the string
                body.insert($urandom_range(0, body.size()), 8'($urandom_range(0, 255)));
                counted++;
            end else if (m == 1) begin
                // pad, then trailing characters that must be ignored
                body = {body, CH_EQUALS};
                counted++;
                junk = $urandom_range(1, 4);
                for (int i = 0; i < junk; i++) body = {body, 8'($urandom_range(0, 255))};
                counted += junk;
            end else begin
                body.delete();
                junk = $urandom_range(1, 6);
                for (int i = 0; i < junk; i++) body = {body, 8'($urandom_range(0, 255))};
                counted = junk;
            end
        end
        foreach (body[i]) push_char(body[i], i == body.size() - 1);
    endtask

    task automatic write_size(input logic [SIZE_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Hold until every item is taken and every result has come back
    task automatic wait_drained();
        while (chars_to_send.size() != 0 || results_due.size() != 0) @(posedge i_clk);
    endtask

    // Source side: present queued characters, with random gaps between items
    always @(negedge i_clk) begin
        if (i_s_tvalid && !char_taken) begin
            // hold the item until it is taken
        end else if (send_wait > 0 || chars_to_send.size() == 0) begin
            i_s_tvalid <= 1'b0;
            if (send_wait > 0) send_wait--;
        end else begin
            i_s_tvalid <= 1'b1;
            i_s_tdata  <= chars_to_send[0].ch;
            i_s_tlast  <= chars_to_send[0].last;
            send_wait = idle_len();
        end
    end

    // Sink side: random stalls
    always @(negedge i_clk) begin
        if (recv_wait > 0) begin
            i_m_tready <= 1'b0;
            recv_wait--;
        end else begin
            i_m_tready <= 1'b1;
            recv_wait = idle_len();
        end
    end

    // Predict on every taken item, then check every delivered result
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        char_taken = 1'b0;
        if (!i_rst_n) begin
            size_reg = '0;
            clear_string();
        end else begin
            if (i_cfg_we) size_reg = i_cfg_wdata;
            if (i_s_tvalid && o_s_tready) begin
                decode_char(i_s_tdata, i_s_tlast);
                chars_to_send.delete(0);
                char_taken = 1'b1;
            end
            if (o_m_tvalid && i_m_tready) begin
                got.data_byte = o_m_tdata;
                got.kind      = t_kind'(o_m_tuser);
                got.final_res = o_m_tlast;
                if (results_due.size() == 0) begin
                    bad_results++;
                    $display("%0t: unexpected result, expected none, %s %02h kind %0d last %0d",
                             $time, "actual byte", got.data_byte, got.kind, got.final_res);
                end else begin
                    want = results_due.pop_front();
                    if (got !== want) begin
                        bad_results++;
                        $display("%0t: mismatch, expected byte %02h kind %0d last %0d,",
                                 $time, want.data_byte, want.kind, want.final_res);
                        $display("%0t:   actual byte %02h kind %0d last %0d",
                                 $time, got.data_byte, got.kind, got.final_res);
                    end
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        logic [SIZE_W-1:0] sizes[NUM_PHASES];
        int                phase_items;
        int                got_items;
        int                target;
        int                r;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed strings, expected size at its reset value of zero
        push_char(CH_EQUALS, 1'b1);
        push_char(8'h00, 1'b1);
        push_char(8'hFF, 1'b0);
        push_char(CH_UPPER_A, 1'b1);
        push_char(CH_UPPER_Z, 1'b1);
        push_char("Q", 1'b0);
        push_char("Q", 1'b1);
        push_char(CH_EQUALS, 1'b0);
        push_char(8'hFF, 1'b0);
        push_char(CH_LOWER_Z, 1'b0);
        push_char(CH_UPPER_A, 1'b1);
        push_char(CH_CR, 1'b0);
        push_char(CH_LF, 1'b0);
        push_char(CH_SPACE, 1'b0);
        push_char(CH_TAB, 1'b1);
        push_char(CH_LOWER_A, 1'b0);
        push_char(CH_LOWER_Z, 1'b0);
        push_char(CH_DIGIT_0, 1'b0);
        push_char(CH_DIGIT_9, 1'b0);
        push_char(CH_PLUS, 1'b0);
        push_char(CH_SLASH, 1'b1);
        wait_drained();
        repeat (SETTLE) @(posedge i_clk);

        // Random strings over several expected sizes, extremes included
        sizes = '{24'd1, 24'hFFFFFF, 24'd3, 24'd0, 24'd2,
                  SIZE_W'($urandom_range(4, 12)),
                  SIZE_W'($urandom_range(13, 24'hFFFFFE)), 24'd5};
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_size(sizes[p]);
            calm = (p == 2 || p == 5);
            phase_items = 0;
            while (phase_items < RANDOM_ITEMS / NUM_PHASES) begin
                target = (sizes[p] <= 16) ? int'(sizes[p]) : $urandom_range(0, 6);
                r = $urandom_range(0, 99);
                if (r < 70) add_string(target, 1'b0, got_items);
                else if (r < 85) add_string($urandom_range(0, 6), 1'b0, got_items);
                else add_string($urandom_range(0, 6), 1'b1, got_items);
                phase_items += got_items;
            end
            wait_drained();
            repeat (SETTLE) @(posedge i_clk);
        end

        repeat (TAIL) @(posedge i_clk);
        if (bad_results == 0 && results_due.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
